@@ design/aceu_pkg.sv @@
// aceu_pkg: shared types and codes for the accumulator execute unit.
// Holds the opcode and request-class enums and the queued request record.
// No dependencies.
package aceu_pkg;

   typedef enum logic [2:0] {
      OP_ADD = 3'd0,
      OP_AND = 3'd1,
      OP_ORR = 3'd2,
      OP_XOR = 3'd3,
      OP_LDR = 3'd4,
      OP_STR = 3'd5,
      OP_JMP = 3'd6,
      OP_JNE = 3'd7
   } op_type;

   typedef enum logic {
      REQ_EXEC  = 1'b0,
      REQ_WRITE = 1'b1
   } req_kind_type;

   // class of a request after decode in the front end
   typedef enum logic [2:0] {
      K_ALU   = 3'd0,
      K_STR   = 3'd1,
      K_JMP   = 3'd2,
      K_JNE   = 3'd3,
      K_WRITE = 3'd4,
      K_FAULT = 3'd5
   } kind_type;

   // decoded request; addr and wval are already masked to the data width
   typedef struct packed {
      kind_type    kind;
      op_type      op;
      logic [7:0]  addr;
      logic [7:0]  wval;
   } item_type;

endpackage

@@ design/aceu_if.sv @@
// aceu_if: valid/ready channel interfaces of the accumulator execute unit.
// aceu_req_if carries requests in, aceu_rsp_if carries results out.
// No dependencies.
interface aceu_req_if;
   logic       valid;
   logic       ready;
   logic       req_type;
   logic [2:0] opcode;
   logic [7:0] operand_address;
   logic [7:0] write_value;

   modport source (output valid, output req_type, output opcode,
                   output operand_address, output write_value, input ready);
   modport sink   (input valid, input req_type, input opcode,
                   input operand_address, input write_value, output ready);
endinterface

interface aceu_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] accumulator;
   logic [7:0] program_counter;
   logic       fault;

   modport source (output valid, output accumulator, output program_counter,
                   output fault, input ready);
   modport sink   (input valid, input accumulator, input program_counter,
                   input fault, output ready);
endinterface

@@ design/aceu_front.sv @@
// aceu_front: accepts requests, decodes and range-checks them, and queues
// them in a two-entry buffer for the back end.
// Depends on aceu_pkg and aceu_if.
module aceu_front #(
   parameter int ARCH_BITS = 8,
   parameter int MEM_WORDS = 256
) (
   input  logic               clock,
   input  logic               reset,
   aceu_req_if.sink           req_chan,
   input  logic               clearing,
   input  logic               pop,
   output logic               head_valid,
   output aceu_pkg::item_type head_item
);

   localparam logic [7:0] ADDR_MASK = (ARCH_BITS >= 8) ? 8'hFF
                                      : 8'((1 << ARCH_BITS) - 1);

   logic [7:0]         addr8;
   logic               in_mem;
   logic               push;
   aceu_pkg::item_type item;
   aceu_pkg::op_type   op;

   aceu_pkg::item_type q_ff [2];
   logic               wr_ptr_ff, wr_ptr_in;
   logic               rd_ptr_ff, rd_ptr_in;
   logic [1:0]         count_ff, count_in;

   // decode
   always_comb begin
      addr8     = req_chan.operand_address & ADDR_MASK;
      in_mem    = {24'd0, addr8} < 32'(MEM_WORDS);
      op        = aceu_pkg::op_type'(req_chan.opcode);
      item.op   = op;
      item.addr = addr8;
      item.wval = req_chan.write_value & ADDR_MASK;
      if (aceu_pkg::req_kind_type'(req_chan.req_type) == aceu_pkg::REQ_WRITE) begin
         item.kind = in_mem ? aceu_pkg::K_WRITE : aceu_pkg::K_FAULT;
      end else begin
         case (op)
            aceu_pkg::OP_JMP: item.kind = aceu_pkg::K_JMP;
            aceu_pkg::OP_JNE: item.kind = aceu_pkg::K_JNE;
            aceu_pkg::OP_STR: item.kind = in_mem ? aceu_pkg::K_STR : aceu_pkg::K_FAULT;
            default:          item.kind = in_mem ? aceu_pkg::K_ALU : aceu_pkg::K_FAULT;
         endcase
      end
   end

   always_comb begin
      req_chan.ready = (count_ff != 2'd2) && !clearing;
      push           = req_chan.valid && req_chan.ready;
      head_valid     = (count_ff != 2'd0);
      head_item      = q_ff[rd_ptr_ff];
      wr_ptr_in      = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in      = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in       = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

@@ design/aceu_back.sv @@
// aceu_back: reads data memory for the queued request, executes it against
// the accumulator and program counter, and holds the result for the sink.
// Depends on aceu_pkg and aceu_if.
module aceu_back #(
   parameter int ARCH_BITS = 8,
   parameter int MEM_WORDS = 256,
   parameter int INSN_STEP = 2
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               head_valid,
   input  aceu_pkg::item_type head_item,
   output logic               pop,
   output logic               clearing,
   aceu_rsp_if.source         rsp_chan
);

   localparam int ADDR_W = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
   localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(MEM_WORDS - 1);

   logic [ARCH_BITS-1:0] mem_ff [MEM_WORDS];
   logic [ARCH_BITS-1:0] rd_ff;
   logic                 byp_ff;
   logic [ARCH_BITS-1:0] byp_data_ff;

   logic                 clr_active_ff;
   logic [ADDR_W-1:0]    clr_idx_ff;

   logic                 b_valid_ff;
   aceu_pkg::item_type   b_item_ff;
   logic [ARCH_BITS-1:0] acc_ff, acc_in;
   logic [ARCH_BITS-1:0] pc_ff, pc_in;

   logic                 rsp_valid_ff;
   logic [7:0]           rsp_acc_ff;
   logic [7:0]           rsp_pc_ff;
   logic                 rsp_fault_ff;

   logic                 b_fire;
   logic                 b_we;
   logic [ARCH_BITS-1:0] b_wdata;
   logic                 fault;
   logic [ADDR_W-1:0]    b_idx;
   logic [ADDR_W-1:0]    head_idx;
   logic [ARCH_BITS-1:0] operand;
   logic [ARCH_BITS-1:0] target;
   logic [ARCH_BITS-1:0] next_pc;
   logic                 mem_we;
   logic [ADDR_W-1:0]    mem_waddr;
   logic [ARCH_BITS-1:0] mem_wdata;

   always_comb begin
      clearing = clr_active_ff;
      b_fire   = b_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
      pop      = head_valid && (!b_valid_ff || b_fire);
      b_idx    = ADDR_W'(b_item_ff.addr);
      head_idx = ADDR_W'(head_item.addr);
      operand  = byp_ff ? byp_data_ff : rd_ff;
      target   = ARCH_BITS'(b_item_ff.addr);
      next_pc  = pc_ff + ARCH_BITS'(INSN_STEP);
   end

   // execute
   always_comb begin
      acc_in  = acc_ff;
      pc_in   = pc_ff;
      b_we    = 1'b0;
      b_wdata = acc_ff;
      fault   = 1'b0;
      case (b_item_ff.kind)
         aceu_pkg::K_ALU: begin
            case (b_item_ff.op)
               aceu_pkg::OP_ADD: acc_in = acc_ff + operand;
               aceu_pkg::OP_AND: acc_in = acc_ff & operand;
               aceu_pkg::OP_ORR: acc_in = acc_ff | operand;
               aceu_pkg::OP_XOR: acc_in = acc_ff ^ operand;
               aceu_pkg::OP_LDR: acc_in = operand;
               default:          acc_in = acc_ff;
            endcase
            pc_in = next_pc;
         end
         aceu_pkg::K_STR: begin
            b_we  = 1'b1;
            pc_in = next_pc;
         end
         aceu_pkg::K_JMP: pc_in = target;
         aceu_pkg::K_JNE: pc_in = (acc_ff != '0) ? target : next_pc;
         aceu_pkg::K_WRITE: begin
            b_we    = 1'b1;
            b_wdata = ARCH_BITS'(b_item_ff.wval);
         end
         default: fault = 1'b1;
      endcase
   end

   // clearing sweep owns the write port after reset
   always_comb begin
      if (clr_active_ff) begin
         mem_we    = 1'b1;
         mem_waddr = clr_idx_ff;
         mem_wdata = '0;
      end else begin
         mem_we    = b_fire && b_we;
         mem_waddr = b_idx;
         mem_wdata = b_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_ff[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rd_ff       <= mem_ff[head_idx];
         // catch a store retiring in the same cycle to the word being read
         byp_ff      <= b_fire && b_we && (b_idx == head_idx);
         byp_data_ff <= b_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         b_item_ff <= head_item;
      end
      if (b_fire) begin
         rsp_acc_ff   <= 8'(acc_in);
         rsp_pc_ff    <= 8'(pc_in);
         rsp_fault_ff <= fault;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff <= 1'b1;
         clr_idx_ff    <= '0;
         b_valid_ff    <= 1'b0;
         acc_ff        <= '0;
         pc_ff         <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (clr_active_ff) begin
            if (clr_idx_ff == LAST_IDX) begin
               clr_active_ff <= 1'b0;
            end
            clr_idx_ff <= clr_idx_ff + 1'b1;
         end
         if (pop) begin
            b_valid_ff <= 1'b1;
         end else if (b_fire) begin
            b_valid_ff <= 1'b0;
         end
         if (b_fire) begin
            acc_ff <= acc_in;
            pc_ff  <= pc_in;
         end
         if (b_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_comb begin
      rsp_chan.valid           = rsp_valid_ff;
      rsp_chan.accumulator     = rsp_acc_ff;
      rsp_chan.program_counter = rsp_pc_ff;
      rsp_chan.fault           = rsp_fault_ff;
   end

endmodule

@@ design/accumulator_cpu_execute_unit.sv @@
// Accumulator machine execute unit, eight instructions plus memory preload.
// Requests enter on req_chan (aceu_req_if sink): req_type 0 executes the
// instruction in opcode/operand_address, req_type 1 writes write_value into
// data memory. Each request gives one result on rsp_chan (aceu_rsp_if
// source): accumulator, program counter and a fault flag for an address
// beyond the memory, in which case no state changes.
// Path: an accepted request waits in the queue, then is read from memory,
// then is executed into the output register.
// Throughput: one request per cycle while rsp_chan takes every result, set
// by the memory read and execute loop on the accumulator; a store followed
// at once by a read of the same word is forwarded without a bubble.
// Reset: accumulator and program counter go to zero and a clearing sweep
// zeroes data memory, one word per cycle, over all MEM_WORDS words; req_chan
// ready stays low until the sweep ends.
// Stall: while rsp_chan is not taken the result holds, the back end stops,
// and the two-entry request queue fills before req_chan ready drops.
// Depends on aceu_pkg, aceu_if, aceu_front and aceu_back.
module accumulator_cpu_execute_unit #(
   parameter int ARCH_BITS = 8,
   parameter int MEM_WORDS = 256,
   parameter int INSN_STEP = 2
) (
   input logic        clock,
   input logic        reset,
   aceu_req_if.sink   req_chan,
   aceu_rsp_if.source rsp_chan
);

   logic               clearing;
   logic               pop;
   logic               head_valid;
   aceu_pkg::item_type head_item;

   aceu_front #(
      .ARCH_BITS (ARCH_BITS),
      .MEM_WORDS (MEM_WORDS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .clearing   (clearing),
      .pop        (pop),
      .head_valid (head_valid),
      .head_item  (head_item)
   );

   aceu_back #(
      .ARCH_BITS (ARCH_BITS),
      .MEM_WORDS (MEM_WORDS),
      .INSN_STEP (INSN_STEP)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_item  (head_item),
      .pop        (pop),
      .clearing   (clearing),
      .rsp_chan   (rsp_chan)
   );

endmodule

@@ design/aceu_checker.sv @@
// aceu_checker: port-level checks on the accumulator execute unit, bound
// to accumulator_cpu_execute_unit.
// Depends only on the top level's ports.
module aceu_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_accumulator,
   input logic [7:0] rsp_program_counter,
   input logic       rsp_fault
);

   logic       req_fire;
   logic       rsp_fire;
   logic [2:0] pending_ff;
   logic [7:0] last_acc_ff;
   logic [7:0] last_pc_ff;

   assign req_fire = req_valid && req_ready;
   assign rsp_fire = rsp_valid && rsp_ready;

   // track requests in flight and the last delivered state
   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff  <= 3'd0;
         last_acc_ff <= 8'd0;
         last_pc_ff  <= 8'd0;
      end else begin
         pending_ff <= pending_ff + 3'(req_fire) - 3'(rsp_fire);
         if (rsp_fire) begin
            last_acc_ff <= rsp_accumulator;
            last_pc_ff  <= rsp_program_counter;
         end
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_accumulator)
         && $stable(rsp_program_counter) && $stable(rsp_fault))
      else $error("result changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_ready)
      else $error("channels not idle after reset");

   a_no_extra: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 3'd0)
      else $error("result without a pending request");

   a_fault_keeps: assert property (@(posedge clock) disable iff (reset)
      rsp_fire && rsp_fault |-> rsp_accumulator == last_acc_ff
         && rsp_program_counter == last_pc_ff)
      else $error("faulting request changed state");

endmodule

bind accumulator_cpu_execute_unit aceu_checker u_aceu_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_chan.valid),
   .req_ready           (req_chan.ready),
   .rsp_valid           (rsp_chan.valid),
   .rsp_ready           (rsp_chan.ready),
   .rsp_accumulator     (rsp_chan.accumulator),
   .rsp_program_counter (rsp_chan.program_counter),
   .rsp_fault           (rsp_chan.fault)
);
